// ----- rtl/core/nrid_pkg.sv -----
// shared types and constants of the nibble run-length image decoder
package nrid_pkg;

    localparam int NIB_W    = 4;
    localparam int PIXEL_W  = 8;
    localparam int LENGTH_W = 12;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_HIGH = CFG_IDX_W'(1);

    // job queue between decoder front and output back
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // one decoded result before palette mapping
    typedef struct packed {
        logic [NIB_W-1:0]    color;
        logic [LENGTH_W-1:0] length;
    } nrid_job_t;

    // a job beat with its valid flag
    typedef struct packed {
        logic      valid;
        nrid_job_t job;
    } nrid_beat_t;

endpackage

// ----- rtl/core/nibble_rle_image_decoder.sv -----
// top level of the nibble run-length image decoder
//
// Decodes a nibble run-length image stream, one 4-bit code per beat, into
// palette-mapped (pixel, length) results; a repeat comes out as a single
// result carrying its length, run literals come out with length 1, and a
// repeat of length zero gives no result. The decoder accepts one nibble
// every clock cycle for as long as its job queue has room; the queue
// (four entries) only fills when the result side holds pop low. When the
// nibble that completes a result is accepted, its job is written into the
// queue; at the queue head it moves through the palette into the result
// register once that register is empty or is being popped. Setting
// image_last on a nibble decodes it as usual and then returns the decoder
// to the start of an image; the palette is kept. The palette is two 64-bit
// registers, written through the configuration channel (index 0: entries
// 0..7, index 1: entries 8..15, entry n in byte n mod 8); cfg_ready is
// always high and writes to other indexes are dropped. Write the palette
// only while no decoded result is still on its way out.
module nibble_rle_image_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    // nibble stream
    input  logic                            push,
    output logic                            full,
    input  logic [nrid_pkg::NIB_W-1:0]      nibble,
    input  logic                            image_last,
    // results
    output logic                            empty,
    input  logic                            pop,
    output logic [nrid_pkg::PIXEL_W-1:0]    pixel,
    output logic [nrid_pkg::LENGTH_W-1:0]   length,
    // palette configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nrid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nrid_pkg::CFG_W-1:0]      cfg_data
);

    logic                   in_accept;
    nrid_pkg::nrid_beat_t   job_beat;
    nrid_pkg::nrid_beat_t   queue_head;
    logic                   queue_take;

    // an accepted beat always advances the decoder state
    assign in_accept = push && !full;
    assign cfg_ready = 1'b1;

    // front: counts, records and the decision to emit
    nrid_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .nibble     (nibble),
        .image_last (image_last),
        .job_out    (job_beat)
    );

    // decouples the decoder from result back-pressure
    nrid_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_beat (job_beat),
        .full    (full),
        .head    (queue_head),
        .rd_take (queue_take)
    );

    // back: palette mapping and the result register
    nrid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (queue_head),
        .take      (queue_take),
        .pop       (pop),
        .empty     (empty),
        .pixel     (pixel),
        .length    (length)
    );

    // the front never emits a job unless a beat was accepted into free room
    a_job_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_beat.valid |-> (in_accept && !full))
        else $error("job emitted without an accepted beat");

    // every result shown carries a nonzero length
    a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (length != '0))
        else $error("result with zero length");

    // a waiting job reaches an empty result register on the next edge
    a_back_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && queue_head.valid) |=> !empty)
        else $error("queued job not moved to result register");

endmodule

// ----- rtl/core/nrid_front.sv -----
// decoder front: count collection and record state machine
module nrid_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [nrid_pkg::NIB_W-1:0]    nibble,
    input  logic                          image_last,
    output nrid_pkg::nrid_beat_t          job_out
);

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_ESC_A = 7'b0000010,
        PH_ESC_B = 7'b0000100,
        PH_WIDE0 = 7'b0001000,
        PH_WIDE1 = 7'b0010000,
        PH_WIDE2 = 7'b0100000,
        PH_DONE  = 7'b1000000
    } phase_t;

    typedef enum logic [4:0] {
        MD_REP_COUNT = 5'b00001,
        MD_REP_COLOR = 5'b00010,
        MD_GROUP     = 5'b00100,
        MD_RUN_COUNT = 5'b01000,
        MD_RUN_LIT   = 5'b10000
    } mode_t;

    phase_t                          phase_reg, phase_next;
    mode_t                           mode_reg, mode_next;
    logic [nrid_pkg::LENGTH_W-1:0]   count_reg, count_next;
    logic [nrid_pkg::LENGTH_W-1:0]   group_reg, group_next;
    logic                            endless_run_reg, endless_run_next;
    logic                            endless_group_reg, endless_group_next;
    nrid_pkg::nrid_beat_t            beat;

    always_comb
    begin
        logic [nrid_pkg::LENGTH_W-1:0] shifted;
        logic [nrid_pkg::LENGTH_W-1:0] count_dec;

        phase_next         = phase_reg;
        mode_next          = mode_reg;
        count_next         = count_reg;
        group_next         = group_reg;
        endless_run_next   = endless_run_reg;
        endless_group_next = endless_group_reg;
        beat.valid         = 1'b0;
        beat.job.color     = nibble;
        beat.job.length    = count_reg;

        shifted = {count_reg[nrid_pkg::LENGTH_W-nrid_pkg::NIB_W-1:0], nibble};

        // count collection
        case (phase_reg)
            PH_IDLE:
            begin
                if (nibble == '0)
                begin
                    phase_next = PH_ESC_A;
                end
                else
                begin
                    count_next = nrid_pkg::LENGTH_W'(nibble);
                    phase_next = PH_DONE;
                end
            end
            PH_ESC_A:
            begin
                count_next = nrid_pkg::LENGTH_W'(nibble);
                phase_next = PH_ESC_B;
            end
            PH_ESC_B:
            begin
                count_next = shifted;
                phase_next = (shifted == '0) ? PH_WIDE0 : PH_DONE;
            end
            PH_WIDE0:
            begin
                count_next = shifted;
                phase_next = PH_WIDE1;
            end
            PH_WIDE1:
            begin
                count_next = shifted;
                phase_next = PH_WIDE2;
            end
            PH_WIDE2:
            begin
                count_next = shifted;
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        count_dec = count_next - nrid_pkg::LENGTH_W'(1);

        // record handling once the count is complete
        if (phase_next == PH_DONE)
        begin
            case (mode_reg)
                MD_REP_COUNT:
                begin
                    if (count_next == nrid_pkg::LENGTH_W'(1))
                    begin
                        mode_next  = MD_RUN_COUNT;
                        phase_next = PH_IDLE;
                    end
                    else if (count_next == nrid_pkg::LENGTH_W'(2))
                    begin
                        mode_next  = MD_GROUP;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        mode_next = MD_REP_COLOR;
                    end
                end
                MD_REP_COLOR:
                begin
                    beat.valid      = (count_next != '0);
                    beat.job.length = count_next;
                    if (endless_group_reg)
                    begin
                        mode_next = MD_REP_COUNT;
                    end
                    else if (group_reg == '0)
                    begin
                        mode_next = MD_RUN_COUNT;
                    end
                    else
                    begin
                        group_next = group_reg - nrid_pkg::LENGTH_W'(1);
                        mode_next  = MD_REP_COUNT;
                    end
                    phase_next = PH_IDLE;
                end
                MD_GROUP:
                begin
                    endless_group_next = (count_next == '0);
                    group_next         = (count_next == '0) ? '0 : count_dec;
                    mode_next          = MD_REP_COUNT;
                    phase_next         = PH_IDLE;
                end
                MD_RUN_COUNT:
                begin
                    endless_run_next = (count_next == '0);
                    mode_next        = MD_RUN_LIT;
                end
                MD_RUN_LIT:
                begin
                    beat.valid      = 1'b1;
                    beat.job.length = nrid_pkg::LENGTH_W'(1);
                    if (!endless_run_reg)
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            mode_next  = MD_REP_COUNT;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    mode_next  = MD_REP_COUNT;
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // end of image returns the decoder to its start
        if (image_last)
        begin
            phase_next         = PH_IDLE;
            mode_next          = MD_REP_COUNT;
            count_next         = '0;
            group_next         = '0;
            endless_run_next   = 1'b0;
            endless_group_next = 1'b0;
        end

        beat.valid = beat.valid & accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            mode_reg          <= MD_REP_COUNT;
            count_reg         <= '0;
            group_reg         <= '0;
            endless_run_reg   <= 1'b0;
            endless_group_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            mode_reg          <= mode_next;
            count_reg         <= count_next;
            group_reg         <= group_next;
            endless_run_reg   <= endless_run_next;
            endless_group_reg <= endless_group_next;
        end
    end

    assign job_out = beat;

endmodule

// ----- rtl/core/nrid_queue.sv -----
// short job queue between decoder front and output back
module nrid_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nrid_pkg::nrid_beat_t   wr_beat,
    output logic                   full,
    output nrid_pkg::nrid_beat_t   head,
    input  logic                   rd_take
);

    nrid_pkg::nrid_job_t                  slot_reg [nrid_pkg::JOB_DEPTH];
    logic [nrid_pkg::JOB_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [nrid_pkg::JOB_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [nrid_pkg::JOB_CNT_W-1:0]       fill_reg, fill_next;
    logic                                 do_wr;
    logic                                 do_rd;

    assign do_wr = wr_beat.valid;
    assign do_rd = rd_take && (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == nrid_pkg::JOB_PTR_W'(nrid_pkg::JOB_DEPTH - 1))
                        ? '0 : wr_ptr_reg + nrid_pkg::JOB_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == nrid_pkg::JOB_PTR_W'(nrid_pkg::JOB_DEPTH - 1))
                        ? '0 : rd_ptr_reg + nrid_pkg::JOB_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + nrid_pkg::JOB_CNT_W'(1);
        end
        else if (!do_wr && do_rd)
        begin
            fill_next = fill_reg - nrid_pkg::JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_beat.job;
        end
    end

    assign full       = (fill_reg == nrid_pkg::JOB_CNT_W'(nrid_pkg::JOB_DEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/nrid_back.sv -----
// output back: palette registers, palette mapping and result register
module nrid_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [nrid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nrid_pkg::CFG_W-1:0]      cfg_data,
    input  nrid_pkg::nrid_beat_t            head,
    output logic                            take,
    input  logic                            pop,
    output logic                            empty,
    output logic [nrid_pkg::PIXEL_W-1:0]    pixel,
    output logic [nrid_pkg::LENGTH_W-1:0]   length
);

    logic [nrid_pkg::CFG_W-1:0]     palette_low_reg;
    logic [nrid_pkg::CFG_W-1:0]     palette_high_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [nrid_pkg::PIXEL_W-1:0]   pixel_reg;
    logic [nrid_pkg::LENGTH_W-1:0]  length_reg;
    logic [nrid_pkg::CFG_W-1:0]     bank;
    logic [nrid_pkg::PIXEL_W-1:0]   mapped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_low_reg  <= '0;
            palette_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nrid_pkg::REG_PALETTE_LOW:  palette_low_reg  <= cfg_data;
                nrid_pkg::REG_PALETTE_HIGH: palette_high_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // palette entry select
    assign bank   = head.job.color[nrid_pkg::NIB_W-1] ? palette_high_reg : palette_low_reg;
    assign mapped = bank[nrid_pkg::PIXEL_W * head.job.color[nrid_pkg::NIB_W-2:0] +:
                         nrid_pkg::PIXEL_W];

    assign take = head.valid && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pixel_reg  <= mapped;
            length_reg <= head.job.length;
        end
    end

    assign empty  = !out_valid_reg;
    assign pixel  = pixel_reg;
    assign length = length_reg;

endmodule

// ----- bench/nibble_rle_image_decoder_tb.sv -----
// self-checking testbench of the nibble run-length image decoder
`timescale 1ns / 100ps

module nibble_rle_image_decoder_tb;

    import nrid_pkg::*;

    // a decoded result: palette-mapped pixel and its repeat length
    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic [LENGTH_W-1:0] length;
    } pixel_run_t;

    // where the decoder stands in collecting a count
    typedef enum logic [2:0] {
        CNT_NEW      = 3'd0,  // awaiting the first nibble of a count
        CNT_ESC_HI   = 3'd1,  // escaped 8-bit count, high nibble next
        CNT_ESC_LO   = 3'd2,  // escaped 8-bit count, low nibble next
        CNT_WIDE_HI  = 3'd3,  // 8-bit escape was zero, 12-bit count follows
        CNT_WIDE_MID = 3'd4,
        CNT_WIDE_LO  = 3'd5,
        CNT_READY    = 3'd6   // count complete, data nibble awaited
    } count_phase_t;

    // which kind of record the decoder is in
    typedef enum logic [2:0] {
        REC_REPEAT_COUNT = 3'd0,
        REC_REPEAT_COLOR = 3'd1,
        REC_GROUP_SIZE   = 3'd2,
        REC_RUN_COUNT    = 3'd3,
        REC_RUN_LITERAL  = 3'd4
    } record_mode_t;

    // how the stream builder writes a count
    typedef enum int {
        ENC_ANY   = 0,
        ENC_SHORT = 1,  // one nonzero nibble
        ENC_BYTE  = 2,  // escape, then two nibbles
        ENC_WIDE  = 3   // escape, zero byte, then three nibbles
    } count_form_t;

    localparam logic [NIB_W-1:0] ESCAPE_NIBBLE  = 4'h0;
    localparam int               COUNT_TO_RUN   = 1;
    localparam int               COUNT_TO_GROUP = 2;
    localparam int               MAX_LENGTH     = 4095;

    localparam int SETTLE_CYCLES  = 8;     // a result passes the queue and the result register, leave slack
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
    localparam int MAX_REPORTS    = 10;

    // dut signals, all inputs known from time zero
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 push       = 1'b0;
    logic                 full;
    logic [NIB_W-1:0]     nibble     = '0;
    logic                 image_last = 1'b0;
    logic                 empty;
    logic                 pop        = 1'b0;
    logic [PIXEL_W-1:0]   pixel;
    logic [LENGTH_W-1:0]  length;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // a beat on each channel, as seen just before the clock edge
    wire in_beat  = push && !full;
    wire out_beat = pop && !empty;
    wire cfg_beat = cfg_valid && cfg_ready;

    // when low, neither side inserts idle bursts
    bit idle_on = 1'b1;

    // decoder prediction state, mirrored from the accepted beats
    logic [CFG_W-1:0]    pal_low  = '0;
    logic [CFG_W-1:0]    pal_high = '0;
    count_phase_t        dec_phase         = CNT_NEW;
    record_mode_t        dec_mode          = REC_REPEAT_COUNT;
    logic [LENGTH_W-1:0] dec_count         = '0;
    logic [LENGTH_W-1:0] dec_group_left    = '0;
    logic                dec_run_endless   = 1'b0;
    logic                dec_group_endless = 1'b0;

    // results still owed by the decoder, oldest first
    pixel_run_t expected_runs[$];

    // nibbles of the image being sent
    logic [NIB_W-1:0] image_nibbles[$];

    int mismatches    = 0;
    int nibbles_sent  = 0;
    int nibbles_seen  = 0;
    int runs_checked  = 0;
    int images_sent   = 0;
    int palette_loads = 0;
    int idle_cycles   = 0;

    nibble_rle_image_decoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .nibble     (nibble),
        .image_last (image_last),
        .empty      (empty),
        .pop        (pop),
        .pixel      (pixel),
        .length     (length),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    //------------------------------------------------------------------
    // prediction
    //------------------------------------------------------------------

    // palette entry for a color nibble: entries 0..7 in the low word
    function automatic logic [PIXEL_W-1:0] palette_entry(input logic [NIB_W-1:0] color);
        logic [CFG_W-1:0] word;
        word = color[3] ? pal_high : pal_low;
        return word[color[2:0] * PIXEL_W +: PIXEL_W];
    endfunction

    // advance the decoder by one nibble; returns 1 when a result comes out
    function automatic bit decode_nibble(input logic [NIB_W-1:0] nib, output pixel_run_t run);
        bit hit;
        hit = 1'b0;
        run = '0;

        // count collection
        case (dec_phase)
            CNT_NEW:
            begin
                if (nib == ESCAPE_NIBBLE)
                    dec_phase = CNT_ESC_HI;
                else
                begin
                    dec_count = LENGTH_W'(nib);
                    dec_phase = CNT_READY;
                end
            end
            CNT_ESC_HI:
            begin
                dec_count = LENGTH_W'(nib);
                dec_phase = CNT_ESC_LO;
            end
            CNT_ESC_LO:
            begin
                dec_count = {dec_count[7:0], nib};
                // an escaped zero byte means a 12-bit count follows
                dec_phase = (dec_count == 0) ? CNT_WIDE_HI : CNT_READY;
            end
            CNT_WIDE_HI:
            begin
                dec_count = {dec_count[7:0], nib};
                dec_phase = CNT_WIDE_MID;
            end
            CNT_WIDE_MID:
            begin
                dec_count = {dec_count[7:0], nib};
                dec_phase = CNT_WIDE_LO;
            end
            CNT_WIDE_LO:
            begin
                dec_count = {dec_count[7:0], nib};
                dec_phase = CNT_READY;
            end
            default: dec_phase = CNT_READY;
        endcase

        if (dec_phase == CNT_READY)
        begin
            case (dec_mode)
                REC_REPEAT_COUNT:
                begin
                    if (dec_count == COUNT_TO_RUN)
                    begin
                        dec_mode  = REC_RUN_COUNT;
                        dec_phase = CNT_NEW;
                    end
                    else if (dec_count == COUNT_TO_GROUP)
                    begin
                        dec_mode  = REC_GROUP_SIZE;
                        dec_phase = CNT_NEW;
                    end
                    else
                        dec_mode = REC_REPEAT_COLOR;  // color nibble follows
                end
                REC_REPEAT_COLOR:
                begin
                    // zero repeat eats its color and gives nothing
                    if (dec_count != 0)
                    begin
                        hit        = 1'b1;
                        run.pixel  = palette_entry(nib);
                        run.length = dec_count;
                    end
                    if (dec_group_endless)
                        dec_mode = REC_REPEAT_COUNT;
                    else if (dec_group_left == 0)
                        dec_mode = REC_RUN_COUNT;
                    else
                    begin
                        dec_group_left = dec_group_left - 1'b1;
                        dec_mode       = REC_REPEAT_COUNT;
                    end
                    dec_phase = CNT_NEW;
                end
                REC_GROUP_SIZE:
                begin
                    // zero group never runs out of repeat records
                    dec_group_endless = (dec_count == 0);
                    dec_group_left    = dec_group_endless ? '0 : dec_count - 1'b1;
                    dec_mode          = REC_REPEAT_COUNT;
                    dec_phase         = CNT_NEW;
                end
                REC_RUN_COUNT:
                begin
                    dec_run_endless = (dec_count == 0);
                    dec_mode        = REC_RUN_LITERAL;
                end
                REC_RUN_LITERAL:
                begin
                    hit        = 1'b1;
                    run.pixel  = palette_entry(nib);
                    run.length = LENGTH_W'(1);
                    if (!dec_run_endless)
                    begin
                        dec_count = dec_count - 1'b1;
                        if (dec_count == 0)
                        begin
                            dec_mode  = REC_REPEAT_COUNT;
                            dec_phase = CNT_NEW;
                        end
                    end
                end
                default:
                begin
                    dec_mode  = REC_REPEAT_COUNT;
                    dec_phase = CNT_NEW;
                end
            endcase
        end
        return hit;
    endfunction

    //------------------------------------------------------------------
    // checking
    //------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // one process watches all three channels, so the palette, the
    // prediction and the result check are updated in a fixed order
    always @(posedge clk)
    begin : result_monitor
        pixel_run_t run;
        pixel_run_t want;
        if (rst_n)
        begin
            if (cfg_beat)
            begin
                // writes to unused indexes are dropped by the block too
                if (cfg_index == REG_PALETTE_LOW)
                    pal_low = cfg_data;
                else if (cfg_index == REG_PALETTE_HIGH)
                    pal_high = cfg_data;
            end

            if (in_beat)
            begin
                nibbles_seen++;
                if (decode_nibble(nibble, run))
                    expected_runs.push_back(run);
                // image end: decoder back to its reset state, palette kept
                if (image_last)
                begin
                    dec_phase         = CNT_NEW;
                    dec_mode          = REC_REPEAT_COUNT;
                    dec_count         = '0;
                    dec_group_left    = '0;
                    dec_run_endless   = 1'b0;
                    dec_group_endless = 1'b0;
                end
            end

            if (out_beat)
            begin
                runs_checked++;
                if (expected_runs.size() == 0)
                    report_mismatch($sformatf("unexpected result pixel=%0h length=%0d",
                                              pixel, length));
                else
                begin
                    want = expected_runs.pop_front();
                    if (pixel !== want.pixel || length !== want.length)
                        report_mismatch($sformatf(
                            "result %0d: pixel exp %0h got %0h, length exp %0d got %0d",
                            runs_checked, want.pixel, pixel, want.length, length));
                end
            end
        end
    end

    // watchdog: a stuck handshake on any side ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_beat || out_beat || cfg_beat)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_runs.size());
                $display("nibble_rle_image_decoder regression: fail");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // result side: pop with random stall bursts
    //------------------------------------------------------------------

    initial
    begin
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    //------------------------------------------------------------------
    // stimulus helpers
    //------------------------------------------------------------------

    // one nibble beat; push stays high afterwards so back-to-back beats
    // need no extra assignment, the caller lowers it when the stream pauses
    task automatic send_nibble(input logic [NIB_W-1:0] nib, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        push       <= 1'b1;
        nibble     <= nib;
        image_last <= last;
        do
            @(posedge clk);
        while (full);
        nibbles_sent++;
    endtask

    // send the built image; noisy images also mark image ends at random
    task automatic send_image(input bit noisy);
        int i;
        bit last;
        for (i = 0; i < image_nibbles.size(); i++)
        begin
            last = (i == image_nibbles.size() - 1) || (noisy && $urandom_range(0, 15) == 0);
            send_nibble(image_nibbles[i], last);
        end
        images_sent++;
    endtask

    // stop the stream and wait until the decoder has nothing in flight
    task automatic drain_results();
        push <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both palette words, optionally followed by a write to an unused index
    task automatic load_palette(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input bit junk);
        int k;
        int n_writes;
        n_writes = junk ? 3 : 2;
        for (k = 0; k < n_writes; k++)
        begin
            cfg_valid <= 1'b1;
            case (k)
                0:
                begin
                    cfg_index <= REG_PALETTE_LOW;
                    cfg_data  <= lo;
                end
                1:
                begin
                    cfg_index <= REG_PALETTE_HIGH;
                    cfg_data  <= hi;
                end
                default:
                begin
                    cfg_index <= REG_PALETTE_HIGH + CFG_IDX_W'($urandom_range(1, 2));
                    cfg_data  <= {$urandom, $urandom};
                end
            endcase
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        palette_loads++;
    endtask

    // every entry different, both nibbles of the entries sweep all values
    function automatic logic [2*CFG_W-1:0] distinct_palette();
        logic [2*CFG_W-1:0] p;
        int n;
        for (n = 0; n < 16; n++)
            p[n * PIXEL_W +: PIXEL_W] = {NIB_W'(n), ~NIB_W'(n)};
        return p;
    endfunction

    // append a count in the requested (or a random) encoding
    function automatic void add_count(input int value, input count_form_t form);
        count_form_t f;
        f = form;
        if (f == ENC_ANY)
            f = count_form_t'($urandom_range(ENC_SHORT, ENC_WIDE));
        if (f == ENC_SHORT && (value < 1 || value > 15))
            f = ENC_BYTE;
        if (f == ENC_BYTE && (value < 1 || value > 255))
            f = ENC_WIDE;
        case (f)
            ENC_SHORT: image_nibbles.push_back(value[3:0]);
            ENC_BYTE:
            begin
                image_nibbles.push_back(ESCAPE_NIBBLE);
                image_nibbles.push_back(value[7:4]);
                image_nibbles.push_back(value[3:0]);
            end
            default:
            begin
                // escape with a zero byte, then the 12-bit count
                image_nibbles.push_back(ESCAPE_NIBBLE);
                image_nibbles.push_back(ESCAPE_NIBBLE);
                image_nibbles.push_back(ESCAPE_NIBBLE);
                image_nibbles.push_back(value[11:8]);
                image_nibbles.push_back(value[7:4]);
                image_nibbles.push_back(value[3:0]);
            end
        endcase
    endfunction

    function automatic void add_repeat(input int count, input logic [NIB_W-1:0] color,
                                       input count_form_t form);
        add_count(count, form);
        image_nibbles.push_back(color);
    endfunction

    function automatic void add_literals(input int n);
        repeat (n) image_nibbles.push_back(NIB_W'($urandom));
    endfunction

    // repeat lengths: mostly short, some escaped, a few extremes
    function automatic int random_repeat_count();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return MAX_LENGTH;
            2, 3:    return $urandom_range(16, 255);
            4:       return $urandom_range(256, MAX_LENGTH - 1);
            default: return $urandom_range(3, 15);
        endcase
    endfunction

    // literal runs stay short so the stream keeps moving through records
    function automatic int random_run_length();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return $urandom_range(41, 255);
        else if (r <= 4)
            return $urandom_range(7, 40);
        else
            return $urandom_range(1, 6);
    endfunction

    // a well-formed image: repeat records (plain or grouped) or skips, each
    // followed by a run record; an endless group or run can only close the image
    function automatic void build_random_image();
        int records;
        int r;
        int g;
        int n;
        image_nibbles.delete();
        records = $urandom_range(1, 8);
        for (r = 0; r < records; r++)
        begin
            case ($urandom_range(0, 9))
                0: add_count(COUNT_TO_RUN, ENC_ANY);
                1:
                begin
                    g = $urandom_range(0, 4);
                    add_count(COUNT_TO_GROUP, ENC_ANY);
                    add_count(g, ENC_ANY);
                    if (g == 0)
                    begin
                        // zero group: repeats only, until the image ends
                        repeat ($urandom_range(1, 4))
                            add_repeat(random_repeat_count(), NIB_W'($urandom), ENC_ANY);
                        break;
                    end
                    repeat (g)
                        add_repeat(random_repeat_count(), NIB_W'($urandom), ENC_ANY);
                end
                default: add_repeat(random_repeat_count(), NIB_W'($urandom), ENC_ANY);
            endcase
            if (r == records - 1 && $urandom_range(0, 9) == 0)
            begin
                // zero run: literals until the image ends
                add_count(0, ENC_WIDE);
                add_literals($urandom_range(1, 20));
            end
            else
            begin
                n = random_run_length();
                add_count(n, ENC_ANY);
                add_literals(n);
            end
        end
    endfunction

    //------------------------------------------------------------------
    // tests
    //------------------------------------------------------------------

    // palette still at reset: a finite group of two repeats, then a run
    task automatic test_reset_palette();
        image_nibbles.delete();
        add_count(COUNT_TO_GROUP, ENC_SHORT);
        add_count(2, ENC_SHORT);
        add_repeat(3, 4'h4, ENC_SHORT);
        add_repeat(6, 4'h1, ENC_SHORT);
        add_count(COUNT_TO_RUN, ENC_SHORT);
        image_nibbles.push_back(4'hA);
        send_image(1'b0);
        drain_results();
    endtask

    // count extremes in every encoding and each zero-count case
    task automatic test_directed_records();
        logic [2*CFG_W-1:0] p;
        p = distinct_palette();
        load_palette(p[CFG_W-1:0], p[2*CFG_W-1:CFG_W], 1'b0);

        // largest short count, single literal of color zero, largest wide count
        image_nibbles.delete();
        add_repeat(15, 4'hF, ENC_SHORT);
        add_count(COUNT_TO_RUN, ENC_SHORT);
        image_nibbles.push_back(4'h0);
        add_repeat(MAX_LENGTH, 4'h9, ENC_WIDE);
        send_image(1'b0);

        // zero group holding a zero repeat and a 255 repeat, then a skip
        // into a zero run that is ended by the image end
        image_nibbles.delete();
        add_count(COUNT_TO_GROUP, ENC_SHORT);
        add_count(0, ENC_WIDE);
        add_repeat(0, 4'h5, ENC_WIDE);
        add_repeat(255, 4'h8, ENC_BYTE);
        add_count(COUNT_TO_RUN, ENC_SHORT);
        add_count(0, ENC_WIDE);
        image_nibbles.push_back(4'h3);
        image_nibbles.push_back(4'hC);
        send_image(1'b0);
        drain_results();
    endtask

    // random images: mostly well formed, some cut short, some pure noise
    task automatic test_random_images(input int budget);
        int start;
        int keep;
        start = nibbles_sent;
        while (nibbles_sent - start < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                image_nibbles.delete();
                add_literals($urandom_range(1, 20));
                send_image(1'b1);
            end
            else
            begin
                build_random_image();
                // broken image: ends in the middle of a record
                if ($urandom_range(0, 7) == 0 && image_nibbles.size() > 1)
                begin
                    keep = $urandom_range(1, image_nibbles.size() - 1);
                    while (image_nibbles.size() > keep)
                        void'(image_nibbles.pop_back());
                end
                send_image(1'b0);
            end
        end
        drain_results();
    endtask

    //------------------------------------------------------------------
    // sequence
    //------------------------------------------------------------------

    initial
    begin
        logic [2*CFG_W-1:0] p;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_palette();
        test_directed_records();

        // random palette, plus a write to an unused index that must be ignored
        load_palette({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        test_random_images(450);

        // all-ones palette
        load_palette('1, '1, 1'b0);
        test_random_images(350);

        // random low half, zero high half
        load_palette({$urandom, $urandom}, '0, 1'b1);
        test_random_images(350);

        // last stretch at full rate on both sides
        idle_on = 1'b0;
        p = distinct_palette();
        load_palette(p[CFG_W-1:0], p[2*CFG_W-1:CFG_W], 1'b0);
        test_random_images(350);

        $display("covered %0d nibbles in %0d images under %0d palette settings",
                 nibbles_seen, images_sent, palette_loads);
        $display("checked %0d results, %0d mismatches", runs_checked, mismatches);
        if (mismatches == 0 && expected_runs.size() == 0)
            $display("nibble_rle_image_decoder regression: pass");
        else
            $display("nibble_rle_image_decoder regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/nrid_pkg.sv
rtl/core/nrid_front.sv
rtl/core/nrid_queue.sv
rtl/core/nrid_back.sv
rtl/core/nibble_rle_image_decoder.sv
bench/nibble_rle_image_decoder_tb.sv
